[hdl/tlm3_pkg.sv]
`timescale 1ns / 1ps

package tlm3_pkg;

  // Fixed field widths.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned COORD_W = 11;
  // Wide enough to hold the largest supported image dimension.
  localparam int unsigned DIM_W   = 14;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;

  // Configuration register map, word addressed.
  localparam int unsigned APB_AW = 4;
  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_MAX_COUNT    = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [PIX_W-1:0]  RST_THRESHOLD    = 8'd2;
  localparam logic [CNT_W-1:0]  RST_MAX_COUNT    = 14'd500;
  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

  localparam logic [DIM_W-1:0] MIN_DIM = 14'd3;

  // 3x3 window, element [3*row + column], row 0 is the oldest line.
  typedef logic [8:0][PIX_W-1:0] window_t;

  localparam int unsigned CENTER = 4;

  // Center above threshold and strictly above all eight neighbors.
  function automatic logic is_peak(input window_t win, input logic [PIX_W-1:0] thr);
    logic ok;
    ok = (win[CENTER] > thr);
    for (int i = 0; i < 9; i++) begin
      if (i != CENTER && win[i] >= win[CENTER]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Clamp a programmed dimension to [3, max_dim].
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(v);
    if (ext < MIN_DIM) begin
      return MIN_DIM;
    end
    if (ext > max_dim) begin
      return max_dim;
    end
    return ext;
  endfunction

endpackage

[hdl/tlm3_line_buf.sv]
`timescale 1ns / 1ps

module tlm3_line_buf #(
  parameter int unsigned DEPTH = tlm3_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [tlm3_pkg::PIX_W-1:0] wr_pixel_i,
  output logic [tlm3_pkg::PIX_W-1:0] rd_above_o,
  output logic [tlm3_pkg::PIX_W-1:0] rd_two_above_o
);
  import tlm3_pkg::*;

  logic [PIX_W-1:0] line_a_mem [DEPTH];
  logic [PIX_W-1:0] line_b_mem [DEPTH];
  logic [PIX_W-1:0] rd_a_q;
  logic [PIX_W-1:0] rd_b_q;

  // The row above moves down one line on the write; its value is the read
  // data of the same column, which holds until the write has happened.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_a_mem[wr_addr_i] <= wr_pixel_i;
      line_b_mem[wr_addr_i] <= rd_a_q;
    end
    if (rd_en_i) begin
      rd_a_q <= line_a_mem[rd_addr_i];
      rd_b_q <= line_b_mem[rd_addr_i];
    end
  end

  assign rd_above_o     = rd_a_q;
  assign rd_two_above_o = rd_b_q;

endmodule

[hdl/threshold_local_max_3x3_core.sv]
`timescale 1ns / 1ps

// 3x3 local maximum picker for a normalized 8-bit response map. Pixels enter
// in raster order, one per clock at full rate: a pixel is accepted in every
// cycle unless a detected corner is waiting in the output register while the
// next one is ready to leave. The line stores are read (one RAM port each) at
// the edge that takes a pixel, and the window compare works from the compare
// stage register, so a corner passes the compare stage and then the output
// register after the transfer of the pixel that completes its window. A
// pixel off the image border is reported when it exceeds the threshold and
// all eight neighbors; corners carry a 1-based index and stop after max_count
// per frame. The line stores need no clearing after reset.
module threshold_local_max_3x3_core #(
  parameter int unsigned MAX_WIDTH  = tlm3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = tlm3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tlm3_pkg::PIX_W-1:0]    pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tlm3_pkg::COORD_W-1:0]  corner_x_o,
  output logic [tlm3_pkg::COORD_W-1:0]  corner_y_o,
  output logic [tlm3_pkg::CNT_W-1:0]    corner_index_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlm3_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tlm3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // Configuration
  logic [PIX_W-1:0]  threshold_q;
  logic [CNT_W-1:0]  max_count_q;
  logic [SIZE_W-1:0] image_width_q;
  logic [SIZE_W-1:0] image_height_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= RST_THRESHOLD;
      max_count_q    <= RST_MAX_COUNT;
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THRESHOLD:    threshold_q    <= pwdata[PIX_W-1:0];
        REG_MAX_COUNT:    max_count_q    <= pwdata[CNT_W-1:0];
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD:    prdata = 32'(threshold_q);
      REG_MAX_COUNT:    prdata = 32'(max_count_q);
      REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
      default:          prdata = '0;
    endcase
  end

  // Raster position of the next pixel
  logic [DIM_W-1:0] last_col;
  logic [DIM_W-1:0] last_row;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic             row_end;
  logic             col_end;
  logic             accept;

  assign last_col = clamp_dim(image_width_q, MAX_W_DIM) - 1'b1;
  assign last_row = clamp_dim(image_height_q, MAX_H_DIM) - 1'b1;
  assign col_end  = (DIM_W'(col_q) >= last_col);
  assign row_end  = (DIM_W'(row_q) >= last_row);
  assign accept   = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Compare stage: holds the pixel while the line store data is read
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pixel_q;
  logic [CW-1:0]    s1_col_q;
  logic [RW-1:0]    s1_row_q;
  logic             s1_interior_q;
  logic             s1_frame_end_q;
  logic             s1_hit;
  logic             s1_stall;
  logic             s1_fire;
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] two_above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q     <= pixel_i;
      s1_col_q       <= col_q;
      s1_row_q       <= row_q;
      s1_interior_q  <= (col_q >= CW'(2)) && (row_q >= RW'(2));
      s1_frame_end_q <= col_end && row_end;
    end
  end

  tlm3_line_buf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i         (clk_i),
    .rd_en_i       (accept),
    .rd_addr_i     (col_q),
    .wr_en_i       (s1_fire),
    .wr_addr_i     (s1_col_q),
    .wr_pixel_i    (s1_pixel_q),
    .rd_above_o    (above),
    .rd_two_above_o(two_above)
  );

  // Window: shift left by one column and insert the new column
  window_t          window_q;
  window_t          window_d;
  logic [CNT_W-1:0] found_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_d[3*r]     = window_q[3*r + 1];
      window_d[3*r + 1] = window_q[3*r + 2];
    end
    window_d[2] = two_above;
    window_d[5] = above;
    window_d[8] = s1_pixel_q;
  end

  assign s1_hit   = s1_interior_q && (found_q < max_count_q) && is_peak(window_d, threshold_q);
  // A corner cannot leave while the output register holds one nobody takes.
  assign s1_stall = s1_valid_q && s1_hit && out_valid_o && !out_ready_i;
  assign s1_fire  = s1_valid_q && !s1_stall;
  assign in_ready_o = !s1_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      found_q  <= '0;
    end else if (s1_fire) begin
      window_q <= window_d;
      if (s1_frame_end_q) begin
        found_q <= '0;
      end else if (s1_hit) begin
        found_q <= found_q + 1'b1;
      end
    end
  end

  // Output register
  logic               out_valid_q;
  logic [COORD_W-1:0] corner_x_q;
  logic [COORD_W-1:0] corner_y_q;
  logic [CNT_W-1:0]   corner_index_q;
  logic [CW-1:0]      x_m1;
  logic [RW-1:0]      y_m1;
  logic               out_load;

  assign x_m1     = s1_col_q - 1'b1;
  assign y_m1     = s1_row_q - 1'b1;
  assign out_load = s1_fire && s1_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      corner_x_q     <= COORD_W'(x_m1);
      corner_y_q     <= COORD_W'(y_m1);
      corner_index_q <= found_q + 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign corner_x_o     = corner_x_q;
  assign corner_y_o     = corner_y_q;
  assign corner_index_o = corner_index_q;

endmodule

[hdl/tlm3_checker.sv]
`timescale 1ns / 1ps

module tlm3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tlm3_pkg::CNT_W-1:0]    corner_index_o
);
  import tlm3_pkg::*;

  // A waiting corner is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("corner withdrawn before transfer");

  // The input only stalls behind a blocked output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A fresh corner follows an earlier pixel transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("corner without a preceding pixel transfer");

  // Corner indices are 1-based.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> corner_index_o != '0)
    else $error("corner index zero");

endmodule

bind threshold_local_max_3x3_core tlm3_checker u_tlm3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .corner_index_o(corner_index_o)
);

[dv/tb_threshold_local_max_3x3_core.sv]
`timescale 1ns / 1ps

module tb_threshold_local_max_3x3_core;
  import tlm3_pkg::*;

  localparam int unsigned MAX_W         = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H         = DEF_MAX_HEIGHT;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PIXEL_TARGET  = 640;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // Middle row of the directed 8x3 frame, column 0 in the low byte.
  localparam logic [7:0][PIX_W-1:0] MID_ROW =
    {8'd0, 8'd12, 8'd0, 8'd9, 8'd9, 8'd0, 8'd8, 8'd0};

  typedef enum logic [1:0] {PAT_NOISE, PAT_SPARSE, PAT_TIES, PAT_FLAT} pattern_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CNT_W-1:0]   idx;
  } corner_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [PIX_W-1:0]    pixel_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [COORD_W-1:0]  corner_x_o;
  logic [COORD_W-1:0]  corner_y_o;
  logic [CNT_W-1:0]    corner_index_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  threshold_local_max_3x3_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .corner_x_o     (corner_x_o),
    .corner_y_o     (corner_y_o),
    .corner_index_o (corner_index_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the configuration registers.
  logic [PIX_W-1:0]  cfg_threshold = RST_THRESHOLD;
  logic [CNT_W-1:0]  cfg_max_count = RST_MAX_COUNT;
  logic [SIZE_W-1:0] cfg_width     = RST_IMAGE_WIDTH;
  logic [SIZE_W-1:0] cfg_height    = RST_IMAGE_HEIGHT;

  // Predicted state of the picker.
  logic [PIX_W-1:0]  row_above     [MAX_W];
  logic [PIX_W-1:0]  row_two_above [MAX_W];
  logic [PIX_W-1:0]  win [3][3];
  int unsigned       col_pos       = 0;
  int unsigned       row_pos       = 0;
  logic [CNT_W-1:0]  found_total   = '0;

  logic [PIX_W-1:0]  pixel_backlog [$];
  corner_t           corners_due   [$];

  bit          idle_on       = 1'b1;
  bit          hold_request  = 1'b0;
  bit          hold_taken    = 1'b0;
  bit          pixel_taken_q = 1'b0;
  int unsigned in_gap        = 0;
  int unsigned rdy_gap       = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned pixels_queued = 0;
  int unsigned frames_queued = 0;
  int unsigned corners_seen  = 0;
  int unsigned reg_writes    = 0;
  corner_t     want_corner;

  initial begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        win[r][k] = '0;
      end
    end
  end

  // Append a pixel to the pending stream.
  function automatic void backlog_add(input logic [PIX_W-1:0] pix);
    pixel_backlog.insert(pixel_backlog.size(), pix);
  endfunction

  // Append a corner to the expected results.
  function automatic void due_add(input corner_t c);
    corners_due.insert(corners_due.size(), c);
  endfunction

  function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < 3) begin
      return 3;
    end
    if (v > hi) begin
      return hi;
    end
    return 32'(v);
  endfunction

  // Shift the window, update the line stores and judge the center.
  task automatic judge_pixel(input logic [PIX_W-1:0] pix);
    int unsigned      w;
    int unsigned      h;
    int unsigned      x;
    logic [PIX_W-1:0] ctr;
    bit               peak;
    corner_t          hit;
    w = eff_dim(cfg_width, MAX_W);
    h = eff_dim(cfg_height, MAX_H);
    x = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = row_two_above[x];
    win[1][2] = row_above[x];
    win[2][2] = pix;
    row_two_above[x] = row_above[x];
    row_above[x] = pix;
    if (col_pos >= 2 && row_pos >= 2 && found_total < cfg_max_count) begin
      ctr = win[1][1];
      peak = (ctr > cfg_threshold);
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          if (!(r == 1 && k == 1) && win[r][k] >= ctr) begin
            peak = 1'b0;
          end
        end
      end
      if (peak) begin
        found_total = found_total + 1'b1;
        hit.x = COORD_W'(col_pos - 1);
        hit.y = COORD_W'(row_pos - 1);
        hit.idx = found_total;
        due_add(hit);
      end
    end
    if (col_pos >= w - 1) begin
      col_pos = 0;
      if (row_pos >= h - 1) begin
        row_pos = 0;
        found_total = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_taken_q <= rst_ni && in_valid_i && in_ready_o;
  end

  // Pixel driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pixel_taken_q) begin
        judge_pixel(pixel_i);
      end
      if (!in_valid_i || pixel_taken_q) begin
        if (in_gap == 0 && idle_on && pixel_backlog.size() != 0 &&
            $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 10);
        end
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          in_valid_i <= 1'b1;
          pixel_i <= pixel_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_request && !hold_taken && out_valid_o) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else if (rdy_gap != 0) begin
      rdy_gap--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      rdy_gap = $urandom_range(1, 10) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Corner monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      corners_seen++;
      if (corners_due.size() == 0) begin
        $error("unexpected corner x=%0d y=%0d index=%0d",
               corner_x_o, corner_y_o, corner_index_o);
        error_count++;
      end else begin
        want_corner = corners_due.pop_front();
        if (corner_x_o !== want_corner.x) begin
          $error("corner_x: expected %0d, actual %0d", want_corner.x, corner_x_o);
          error_count++;
        end
        if (corner_y_o !== want_corner.y) begin
          $error("corner_y: expected %0d, actual %0d", want_corner.y, corner_y_o);
          error_count++;
        end
        if (corner_index_o !== want_corner.idx) begin
          $error("corner_index: expected %0d, actual %0d", want_corner.idx, corner_index_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_threshold_local_max_3x3_core: FAIL");
      $finish;
    end
  end

  // Write one register, then read it back.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] want;
    logic [31:0] got;
    want = '0;
    case (idx)
      REG_THRESHOLD: begin
        cfg_threshold = data[PIX_W-1:0];
        want[PIX_W-1:0] = data[PIX_W-1:0];
      end
      REG_MAX_COUNT: begin
        cfg_max_count = data[CNT_W-1:0];
        want[CNT_W-1:0] = data[CNT_W-1:0];
      end
      REG_IMAGE_WIDTH: begin
        cfg_width = data[SIZE_W-1:0];
        want[SIZE_W-1:0] = data[SIZE_W-1:0];
      end
      default: begin
        cfg_height = data[SIZE_W-1:0];
        want[SIZE_W-1:0] = data[SIZE_W-1:0];
      end
    endcase
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    if (got !== want) begin
      $error("register %0d: expected %0d, actual %0d", idx, want, got);
      error_count++;
    end
  endtask

  task automatic program_block(input logic [31:0] thr, input logic [31:0] maxc,
                               input logic [31:0] w, input logic [31:0] h);
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_MAX_COUNT, maxc);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
  endtask

  // Random bits above the register field, which the block must ignore.
  function automatic logic [31:0] with_junk(input logic [31:0] v, input int unsigned w);
    if ($urandom_range(0, 3) == 0) begin
      return v | ($urandom << w);
    end
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(input pattern_e pat);
    case (pat)
      PAT_NOISE:  return PIX_W'($urandom_range(0, 255));
      PAT_SPARSE: begin
        if ($urandom_range(0, 11) == 0) begin
          return PIX_W'($urandom_range(100, 255));
        end
        return PIX_W'($urandom_range(0, 20));
      end
      PAT_TIES:   return PIX_W'($urandom_range(0, 3));
      default:    return 8'd77;
    endcase
  endfunction

  task automatic queue_frame(input pattern_e pat);
    int unsigned n;
    n = eff_dim(cfg_width, MAX_W) * eff_dim(cfg_height, MAX_H);
    repeat (n) backlog_add(make_pixel(pat));
    pixels_queued += n;
    frames_queued++;
  endtask

  // Hold the stream until every pixel and every corner has gone through.
  task automatic wait_idle();
    while (pixel_backlog.size() != 0 || in_valid_i || corners_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    pattern_e    pat;
    logic [31:0] thr;
    logic [31:0] maxc;
    logic [31:0] w;
    logic [31:0] h;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sizes below three act as three; a lone peak of 1 beats threshold 0.
    program_block(32'd0, 32'd1, 32'd2, 32'd0);
    for (int i = 0; i < 9; i++) begin
      backlog_add((i == 4) ? 8'd1 : 8'd0);
    end
    pixels_queued += 9;
    frames_queued++;
    wait_idle();

    // Center equal to threshold, tied neighbors, then one clean peak.
    program_block(32'd8, 32'd1, 32'd8, 32'd3);
    for (int i = 0; i < 24; i++) begin
      backlog_add((i >= 8 && i < 16) ? MID_ROW[i - 8] : 8'd0);
    end
    pixels_queued += 24;
    frames_queued++;
    wait_idle();

    while (pixels_queued < PIXEL_TARGET) begin
      case ($urandom_range(0, 7))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(0, 200);
      endcase
      case ($urandom_range(0, 7))
        0:       maxc = 0;
        1:       maxc = 1;
        2:       maxc = $urandom_range(2, 5);
        3:       maxc = 16383;
        default: maxc = $urandom_range(1, 10000);
      endcase
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      program_block(with_junk(thr, PIX_W), with_junk(maxc, CNT_W),
                    with_junk(w, SIZE_W), with_junk(h, SIZE_W));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        pat = pattern_e'($urandom_range(0, 3));
        queue_frame(pat);
      end
      wait_idle();
    end

    // Longer frames at full rate; the receiver holds off once in the first.
    idle_on = 1'b0;
    program_block($urandom_range(0, 60), 32'd10000, 32'd120, 32'd3);
    hold_request = 1'b1;
    queue_frame(PAT_NOISE);
    wait_idle();
    program_block($urandom_range(0, 60), 32'd16383, 32'd3, 32'd120);
    queue_frame(PAT_NOISE);
    wait_idle();

    if (corners_due.size() != 0) begin
      $error("%0d expected corners never arrived", corners_due.size());
      error_count++;
    end
    $display("Streamed %0d pixels in %0d frames over %0d register writes.",
             pixels_queued, frames_queued, reg_writes);
    $display("Compared %0d corners, frame sizes from 3x3 up to 120 pixels on a side.",
             corners_seen);
    if (error_count == 0) begin
      $display("tb_threshold_local_max_3x3_core: PASS");
    end else begin
      $display("tb_threshold_local_max_3x3_core: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/tlm3_pkg.sv
hdl/tlm3_line_buf.sv
hdl/threshold_local_max_3x3_core.sv
hdl/tlm3_checker.sv
dv/tb_threshold_local_max_3x3_core.sv
